>>> hdl/sbp_pkg.sv
// Shared widths for the sphere/box penetration push pipeline.
package sbp_pkg;
	localparam int unsigned COORD_W   = 32;
	localparam int unsigned RAD_W     = 31;
	localparam int unsigned SQ_W      = 2 * COORD_W;
	localparam int unsigned ROOT_W    = SQ_W / 2;
	localparam int unsigned PROD_W    = COORD_W + RAD_W;
	localparam int unsigned QUOT_W    = RAD_W;
endpackage

>>> hdl/sphere_box_penetration_push_top.sv
// Sphere against box contact test with penetration push, fully pipelined.
// Stages from accepted input to result: 3 front stages, 32 square
// root stages, 2 scale stages, 31 divide stages, output register.
// Throughput: one transaction per cycle; the whole pipeline holds on out_stall.
// The square root and the per-axis dividers each resolve one bit per stage.
// Reset clears all valid bits; payload registers are not reset.
module sphere_box_penetration_push_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic signed [31:0] center_z,
	input  logic        [30:0] sphere_radius,
	input  logic signed [31:0] box_min_x,
	input  logic signed [31:0] box_min_y,
	input  logic signed [31:0] box_min_z,
	input  logic signed [31:0] box_max_x,
	input  logic signed [31:0] box_max_y,
	input  logic signed [31:0] box_max_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               overlap,
	output logic signed [31:0] push_x,
	output logic signed [31:0] push_y,
	output logic signed [31:0] push_z
);
	localparam int unsigned CW = sbp_pkg::COORD_W;
	localparam int unsigned RW = sbp_pkg::RAD_W;
	localparam int unsigned SW = sbp_pkg::SQ_W;
	localparam int unsigned DW = sbp_pkg::ROOT_W;
	localparam int unsigned PW = sbp_pkg::PROD_W;
	localparam int unsigned QW = sbp_pkg::QUOT_W;
	localparam int unsigned SIDE_W = 3 * CW + 3 + RW;

	logic en;
	logic out_valid_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	logic signed [CW-1:0] c_in  [0:2];
	logic signed [CW-1:0] lo_in [0:2];
	logic signed [CW-1:0] hi_in [0:2];
	assign c_in  = '{center_x, center_y, center_z};
	assign lo_in = '{box_min_x, box_min_y, box_min_z};
	assign hi_in = '{box_max_x, box_max_y, box_max_z};

	// stage 1: clamp and offset magnitude
	logic [CW-1:0] mag_s1 [0:2];
	logic [2:0]    neg_s1;
	logic [RW-1:0] rad_s1;
	logic          vld_s1;

	for (genvar i = 0; i < 3; i++) begin : g_clamp
		logic signed [CW-1:0] cl;
		logic signed [CW:0]   d;
		always_comb begin
			priority if (c_in[i] < lo_in[i]) cl = lo_in[i];
			else if (c_in[i] > hi_in[i])     cl = hi_in[i];
			else                             cl = c_in[i];
			d = (CW+1)'(c_in[i]) - (CW+1)'(cl);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				mag_s1[i] <= d[CW] ? CW'(-d) : CW'(d);
				neg_s1[i] <= d[CW];
			end
		end
	end

	// stage 2: squares
	logic [SW-1:0] sq_s2 [0:2];
	logic [CW-1:0] mag_s2 [0:2];
	logic [2:0]    neg_s2;
	logic [RW-1:0] rad_s2;
	logic          vld_s2;

	// stage 3: saturating sum
	logic [SW-1:0] sum_s3;
	logic [CW-1:0] mag_s3 [0:2];
	logic [2:0]    neg_s3;
	logic [RW-1:0] rad_s3;
	logic          vld_s3;

	logic [SW+1:0] sum_full;
	assign sum_full = (SW+2)'(sq_s2[0]) + (SW+2)'(sq_s2[1]) + (SW+2)'(sq_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1 <= sphere_radius;
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]  <= mag_s1[i] * mag_s1[i];
				mag_s2[i] <= mag_s1[i];
				mag_s3[i] <= mag_s2[i];
			end
			neg_s2 <= neg_s1;
			rad_s2 <= rad_s1;
			sum_s3 <= (sum_full[SW+1:SW] != 2'b00) ? {SW{1'b1}} : sum_full[SW-1:0];
			neg_s3 <= neg_s2;
			rad_s3 <= rad_s2;
		end
	end

	// square root
	logic              sq_vld;
	logic [DW-1:0]     dist_root;
	logic [SIDE_W-1:0] sq_side;

	sbp_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_rad   (sum_s3),
		.in_side  ({mag_s3[0], mag_s3[1], mag_s3[2], neg_s3, rad_s3}),
		.out_vld  (sq_vld),
		.out_root (dist_root),
		.out_side (sq_side)
	);

	logic [CW-1:0] sq_mag [0:2];
	logic [2:0]    sq_neg;
	logic [RW-1:0] sq_rad;
	assign {sq_mag[0], sq_mag[1], sq_mag[2], sq_neg, sq_rad} = sq_side;

	// stage 4: compare and penetration depth
	logic [RW-1:0] pen_s4;
	logic [DW-1:0] dist_s4;
	logic [CW-1:0] mag_s4 [0:2];
	logic [2:0]    neg_s4;
	logic          ov_s4;
	logic          nz_s4;
	logic          vld_s4;

	// stage 5: scale magnitudes by depth
	logic [PW-1:0] prod_s5 [0:2];
	logic [DW-1:0] dist_s5;
	logic [2:0]    neg_s5;
	logic          ov_s5;
	logic          nz_s5;
	logic          vld_s5;

	logic ov_c;
	assign ov_c = dist_root <= DW'(sq_rad);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= sq_vld;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pen_s4  <= ov_c ? RW'(DW'(sq_rad) - dist_root) : '0;
			dist_s4 <= dist_root;
			mag_s4  <= sq_mag;
			neg_s4  <= sq_neg;
			ov_s4   <= ov_c;
			nz_s4   <= dist_root != '0;
			for (int i = 0; i < 3; i++) begin
				prod_s5[i] <= mag_s4[i] * pen_s4;
			end
			dist_s5 <= dist_s4;
			neg_s5  <= neg_s4;
			ov_s5   <= ov_s4;
			nz_s5   <= nz_s4;
		end
	end

	// dividers; axis 0 carries the shared flags
	logic          dv_vld;
	logic [QW-1:0] quot [0:2];
	logic          dv_neg [0:2];
	logic          dv_ov;
	logic          dv_nz;

	sbp_div #(.SIDE_W(3)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.in_num   (prod_s5[0]),
		.in_den   (dist_s5),
		.in_side  ({ov_s5, nz_s5, neg_s5[0]}),
		.out_vld  (dv_vld),
		.out_quot (quot[0]),
		.out_side ({dv_ov, dv_nz, dv_neg[0]})
	);

	sbp_div #(.SIDE_W(1)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.in_num   (prod_s5[1]),
		.in_den   (dist_s5),
		.in_side  (neg_s5[1]),
		.out_vld  (),
		.out_quot (quot[1]),
		.out_side (dv_neg[1])
	);

	sbp_div #(.SIDE_W(1)) u_div_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s5),
		.in_num   (prod_s5[2]),
		.in_den   (dist_s5),
		.in_side  (neg_s5[2]),
		.out_vld  (),
		.out_quot (quot[2]),
		.out_side (dv_neg[2])
	);

	// output register; quotient never exceeds the depth, so no clipping is needed
	logic signed [CW-1:0] push_c [0:2];
	for (genvar i = 0; i < 3; i++) begin : g_push
		logic signed [CW-1:0] q;
		assign q = CW'(quot[i]);
		assign push_c[i] = !(dv_ov && dv_nz) ? '0 : (dv_neg[i] ? -q : q);
	end

	logic                 overlap_q;
	logic signed [CW-1:0] push_x_q;
	logic signed [CW-1:0] push_y_q;
	logic signed [CW-1:0] push_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			overlap_q <= dv_ov;
			push_x_q  <= push_c[0];
			push_y_q  <= push_c[1];
			push_z_q  <= push_c[2];
		end
	end

	assign out_valid = out_valid_q;
	assign overlap   = overlap_q;
	assign push_x    = push_x_q;
	assign push_y    = push_y_q;
	assign push_z    = push_z_q;
endmodule

>>> hdl/sbp_sqrt.sv
// Pipelined integer square root, one root bit per register stage.
module sbp_sqrt #(
	parameter int unsigned SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [sbp_pkg::SQ_W-1:0]    in_rad,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_vld,
	output logic [sbp_pkg::ROOT_W-1:0]  out_root,
	output logic [SIDE_W-1:0]           out_side
);
	localparam int unsigned N  = sbp_pkg::ROOT_W;
	localparam int unsigned RW = N + 1;

	logic [RW-1:0]               rem_s  [0:N];
	logic [N-1:0]                root_s [0:N];
	logic [sbp_pkg::SQ_W-1:0]    val_s  [0:N];
	logic [SIDE_W-1:0]           side_s [0:N];
	logic                        vld_s  [0:N];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign val_s[0]  = in_rad;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic          ge;
		assign cur   = {rem_s[k], val_s[k][sbp_pkg::SQ_W-1 -: 2]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? RW'(cur - trial) : RW'(cur);
				root_s[k+1] <= {root_s[k][N-2:0], ge};
				val_s[k+1]  <= {val_s[k][sbp_pkg::SQ_W-3:0], 2'b00};
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_root = root_s[N];
	assign out_side = side_s[N];
endmodule

>>> hdl/sbp_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module sbp_div #(
	parameter int unsigned SIDE_W = 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_vld,
	input  logic [sbp_pkg::PROD_W-1:0]  in_num,
	input  logic [sbp_pkg::ROOT_W-1:0]  in_den,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_vld,
	output logic [sbp_pkg::QUOT_W-1:0]  out_quot,
	output logic [SIDE_W-1:0]           out_side
);
	localparam int unsigned N  = sbp_pkg::QUOT_W;
	localparam int unsigned DW = sbp_pkg::ROOT_W;

	// quotient is known to fit N bits, so the top bits start as the remainder
	logic [DW-1:0]   rem_s  [0:N];
	logic [N-1:0]    num_s  [0:N];
	logic [N-1:0]    quot_s [0:N];
	logic [DW-1:0]   den_s  [0:N];
	logic [SIDE_W-1:0] side_s [0:N];
	logic            vld_s  [0:N];

	assign rem_s[0]  = in_num[sbp_pkg::PROD_W-1 -: DW];
	assign num_s[0]  = in_num[N-1:0];
	assign quot_s[0] = '0;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;
	assign vld_s[0]  = in_vld;

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [DW:0] cur;
		logic        ge;
		assign cur = {rem_s[k], num_s[k][N-1]};
		assign ge  = cur >= {1'b0, den_s[k]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? DW'(cur - {1'b0, den_s[k]}) : DW'(cur);
				num_s[k+1]  <= {num_s[k][N-2:0], 1'b0};
				quot_s[k+1] <= {quot_s[k][N-2:0], ge};
				den_s[k+1]  <= den_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[N];
	assign out_quot = quot_s[N];
	assign out_side = side_s[N];
endmodule

>>> bench/sphere_box_penetration_push_top_test.sv
// Testbench for the sphere/box penetration push pipeline: random and corner checks.
`timescale 1ns / 100ps

module sphere_box_penetration_push_top_test;
	typedef struct packed {
		logic signed [sbp_pkg::COORD_W-1:0] cx, cy, cz;
		logic        [sbp_pkg::RAD_W-1:0]   rad;
		logic signed [sbp_pkg::COORD_W-1:0] mnx, mny, mnz, mxx, mxy, mxz;
	} query_t;

	typedef struct packed {
		logic                               hit;
		logic signed [sbp_pkg::COORD_W-1:0] px, py, pz;
	} push_t;

	localparam int LATENCY = 69;
	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] center_x = '0, center_y = '0, center_z = '0;
	logic [30:0] sphere_radius = '0;
	logic signed [31:0] box_min_x = '0, box_min_y = '0, box_min_z = '0;
	logic signed [31:0] box_max_x = '0, box_max_y = '0, box_max_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic overlap;
	logic signed [31:0] push_x, push_y, push_z;

	query_t pending_queries[$];
	push_t expected_pushes[$];
	int errors = 0;
	int cycles = 0;
	bit stimulus_done = 0;
	bit hold_sender = 0;
	int hold_cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;

	sphere_box_penetration_push_top u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [63:0] floor_sqrt(logic [63:0] v);
		logic [63:0] op, res, one;
		op = v;
		res = 0;
		one = 64'h1 << 62;
		while (one > op)
			one >>= 2;
		while (one != 0) begin
			if (op >= res + one) begin
				op -= res + one;
				res = (res >> 1) + one;
			end else begin
				res >>= 1;
			end
			one >>= 2;
		end
		return res;
	endfunction

	function automatic push_t predict_push(query_t q);
		logic signed [63:0] c[3], lo[3], hi[3], d[3], cl;
		logic [63:0] m[3], sum, sq, root_len, pen, quot;
		logic [127:0] prod;
		push_t r;
		c = '{q.cx, q.cy, q.cz};
		lo = '{q.mnx, q.mny, q.mnz};
		hi = '{q.mxx, q.mxy, q.mxz};
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			cl = (c[i] < lo[i]) ? lo[i] : (c[i] > hi[i]) ? hi[i] : c[i];
			d[i] = c[i] - cl;
			m[i] = (d[i] < 0) ? -d[i] : d[i];
			sq = m[i] * m[i];
			sum = (sum + sq < sum) ? 64'hFFFF_FFFF_FFFF_FFFF : sum + sq;
		end
		root_len = floor_sqrt(sum);
		r = '0;
		if (root_len > {33'd0, q.rad})
			return r;
		r.hit = 1'b1;
		pen = {33'd0, q.rad} - root_len;
		if (root_len != 0) begin
			for (int i = 0; i < 3; i++) begin
				prod = m[i] * pen;
				quot = prod / root_len;
				if (quot > 64'h7FFF_FFFF)
					quot = (d[i] < 0) ? 64'h8000_0000 : 64'h7FFF_FFFF;
				if (d[i] < 0)
					quot = -quot;
				if (i == 0) r.px = quot[31:0];
				else if (i == 1) r.py = quot[31:0];
				else r.pz = quot[31:0];
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 92) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			default: return $urandom;
		endcase
	endfunction

	// mostly near-contact geometry so the hit path is well covered
	function automatic query_t random_query();
		query_t q;
		logic signed [31:0] base, span;
		int mode;
		mode = $urandom_range(9);
		if (mode < 2) begin
			q = {$urandom, $urandom, $urandom, 31'($urandom), $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
			if (mode == 1) begin
				q.cx = pick_coord(); q.mxy = pick_coord(); q.mnz = pick_coord();
			end
			return q;
		end
		base = $urandom_range(32'h0100_0000) - 32'h0080_0000;
		span = $urandom_range(32'h0004_0000);
		q.mnx = base; q.mxx = base + span;
		q.mny = base - $urandom_range(32'h2_0000); q.mxy = q.mny + span;
		q.mnz = base + $urandom_range(32'h2_0000); q.mxz = q.mnz + span;
		if (mode == 2) q.mxz = q.mnz - $urandom_range(32'h1_0000);
		q.rad = $urandom_range(32'h0006_0000);
		if (mode == 3) q.rad = $urandom_range(31'h7FFF_FFFF, 31'h4000_0000);
		q.cx = base + $signed($urandom_range(32'h000C_0000)) - 32'h0004_0000;
		q.cy = base + $signed($urandom_range(32'h000C_0000)) - 32'h0004_0000;
		q.cz = base + $signed($urandom_range(32'h000C_0000)) - 32'h0004_0000;
		return q;
	endfunction

	task automatic add_query(query_t q);
		pending_queries.push_back(q);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("sphere_box_penetration_push_top test failed");
			$finish;
		end
	end

	// driver
	always @(posedge clk) begin
		query_t q;
		if (in_valid && !in_stall) begin
			expected_pushes.push_back(predict_push({center_x, center_y, center_z,
				sphere_radius, box_min_x, box_min_y, box_min_z,
				box_max_x, box_max_y, box_max_z}));
		end
		if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_valid <= 1'b0;
			end else if (arst_n && !hold_sender && pending_queries.size() > 0) begin
				q = pending_queries.pop_front();
				{center_x, center_y, center_z, sphere_radius, box_min_x, box_min_y,
					box_min_z, box_max_x, box_max_y, box_max_z} <= q;
				in_valid <= 1'b1;
				send_gap <= pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		push_t exp_push;
		if (out_valid && !out_stall) begin
			if (expected_pushes.size() == 0) begin
				$error("unexpected transaction: overlap %0d push %0d %0d %0d",
					overlap, push_x, push_y, push_z);
				errors++;
			end else begin
				exp_push = expected_pushes.pop_front();
				if (overlap !== exp_push.hit) begin
					$error("overlap: expected %0d actual %0d", exp_push.hit, overlap);
					errors++;
				end
				if (push_x !== exp_push.px) begin
					$error("push_x: expected %0d actual %0d", exp_push.px, push_x);
					errors++;
				end
				if (push_y !== exp_push.py) begin
					$error("push_y: expected %0d actual %0d", exp_push.py, push_y);
					errors++;
				end
				if (push_z !== exp_push.pz) begin
					$error("push_z: expected %0d actual %0d", exp_push.pz, push_z);
					errors++;
				end
			end
		end
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (!stimulus_done || $urandom_range(3) == 0)
				recv_gap <= pick_gap();
		end
	end

	initial begin
		query_t q;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// inside box: zero push with overlap
		add_query({32'sd0, 32'sd0, 32'sd0, 31'd0, -32'sd65536, -32'sd65536,
			-32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536});
		// touching on x, exact radius
		add_query({32'sh3_0000, 32'sd0, 32'sd0, 31'h2_0000, -32'sd65536, -32'sd65536,
			-32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536});
		// just out of reach
		add_query({32'sh3_0001, 32'sd0, 32'sd0, 31'h2_0000, -32'sd65536, -32'sd65536,
			-32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536});
		// negative side on all axes, diagonal push
		add_query({-32'sh2_0000, -32'sh2_0000, -32'sh2_0000, 31'h4_0000, -32'sd65536,
			-32'sd65536, -32'sd65536, 32'sd65536, 32'sd65536, 32'sd65536});
		// maximal radius, extreme coordinates
		add_query({32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000,
			32'sh7FFF_FFFF, 32'sh8000_0000});
		// sum of squares overflow
		add_query({32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h7FFF_FFFF,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000});
		// big push component, radius max and tiny distance
		add_query({32'sd1, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sd0});
		add_query({-32'sd1, 32'sd0, 32'sd0, 31'h7FFF_FFFF, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0, 32'sd0});
		// inverted box: center between bounds, below min, above max
		add_query({32'sd0, 32'sd0, 32'sd0, 31'h1_0000, 32'sh1_0000, 32'sd0, 32'sd0,
			-32'sh1_0000, 32'sd0, 32'sd0});
		add_query({-32'sh2_0000, 32'sd0, 32'sd0, 31'h4_0000, 32'sh1_0000, 32'sd0,
			32'sd0, -32'sh1_0000, 32'sd0, 32'sd0});
		add_query({32'sd0, 32'sh2_0000, 32'sd0, 31'h4_0000, 32'sd0, 32'sh3_0000,
			32'sd0, 32'sd0, -32'sh1_0000, 32'sd0});
		// zero radius miss, all-zero query
		add_query({32'sd5, 32'sd0, 32'sd0, 31'd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
			32'sd0, 32'sd0});
		add_query('0);
		add_query('1);

		for (int i = 0; i < 700; i++)
			add_query(random_query());
		wait (pending_queries.size() == 0);

		// receiver holds off long while sender keeps offering
		hold_cycles = 400;
		for (int i = 0; i < 300; i++)
			add_query(random_query());
		wait (hold_cycles == 0);
		wait (pending_queries.size() == 0);

		// sender pauses until the pipeline drains
		hold_sender = 1;
		wait (expected_pushes.size() == 0 && !in_valid);
		hold_sender = 0;

		for (int i = 0; i < 740; i++)
			add_query(random_query());
		wait (pending_queries.size() == 0);
		@(posedge clk);
		wait (!in_valid);
		stimulus_done = 1;
		wait (expected_pushes.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0 && expected_pushes.size() == 0) begin
			$display("sphere_box_penetration_push_top test passed");
		end else begin
			$display("sphere_box_penetration_push_top test failed");
		end
		$finish;
	end
endmodule

>>> sphere_box_penetration_push_top.f
hdl/sbp_pkg.sv
hdl/sbp_sqrt.sv
hdl/sbp_div.sv
hdl/sphere_box_penetration_push_top.sv
bench/sphere_box_penetration_push_top_test.sv
